// File: rtl/axis_angle_rotation_matrix_top_defines.svh
// assertion helpers for the rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define AARM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define AARM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/aarm_pkg.sv
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int W    = 32;
    localparam int CW   = 36;
    localparam int SW   = 64;
    localparam int FRAC = 30;

    localparam int CORDIC_STAGES = 24;
    localparam int ATAN_ENTRIES  = 30;
    localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;

    localparam int SQRT_STEPS = SW / 2;
    localparam int DIV_STEPS  = W - 1;
    localparam int NW         = W + DIV_STEPS;

    // pipeline stage indices
    localparam int ST_IN    = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_NRM_A = 3;
    localparam int ST_NRM_B = 4;
    localparam int ST_SQRT0 = 5;
    localparam int ST_NUM   = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DIV0  = ST_NUM + 1;
    localparam int ST_SGN   = ST_DIV0 + DIV_STEPS;
    localparam int ST_MUL1  = ST_SGN + 1;
    localparam int ST_MUL2  = ST_MUL1 + 1;
    localparam int ST_OUT   = ST_MUL2 + 1;
    localparam int NUM_ST   = ST_OUT + 1;

    typedef logic [NUM_ST-1:0]   t_stage_vec;
    typedef logic signed [W-1:0] t_word;
    typedef logic signed [CW-1:0] t_cw;
    typedef logic [W-1:0]        t_mag;
    typedef logic [4:0]          t_shamt;

    localparam t_cw   ONE_Q30     = t_cw'(1073741824);
    localparam t_cw   PI_Q28      = t_cw'(843314857);
    localparam t_cw   TWO_PI_Q28  = t_cw'(1686629713);
    localparam t_cw   HALF_PI_Q28 = t_cw'(421657428);
    localparam t_cw   GAIN_Q30    = t_cw'(652032874);
    localparam t_word ONE_WORD    = t_word'(1073741824);

    localparam logic signed [CW:0] SAT_HI = (CW+1)'(64'sd2147483647);
    localparam logic signed [CW:0] SAT_LO = -SAT_HI - (CW+1)'(1);

    // atan(2^-i) in Q2.30
    localparam int ATAN_TAB [ATAN_ENTRIES] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2
    };

    // q30 product, rounded half up then floored
    function automatic t_cw mul_q30(input t_cw a, input t_cw b);
        logic signed [2*CW-1:0] p;
        p = a * b + (2*CW)'(64'sd536870912);
        mul_q30 = t_cw'(p >>> FRAC);
    endfunction

    function automatic t_word sat_word(input logic signed [CW:0] v);
        if (v > SAT_HI) begin
            sat_word = t_word'(SAT_HI);
        end else if (v < SAT_LO) begin
            sat_word = t_word'(SAT_LO);
        end else begin
            sat_word = t_word'(v);
        end
    endfunction

endpackage

// File: rtl/aarm_in_if.sv
`timescale 1ns / 1ps
interface aarm_in_if;
    import aarm_pkg::*;

    logic  valid;
    logic  ready;
    t_word axis_x;
    t_word axis_y;
    t_word axis_z;
    t_word angle;

    modport source (output valid, output axis_x, output axis_y, output axis_z,
                    output angle, input ready);
    modport sink   (input valid, input axis_x, input axis_y, input axis_z,
                    input angle, output ready);
endinterface

// File: rtl/aarm_out_if.sv
`timescale 1ns / 1ps
interface aarm_out_if;
    import aarm_pkg::*;

    logic  valid;
    logic  ready;
    t_word r00;
    t_word r01;
    t_word r02;
    t_word r10;
    t_word r11;
    t_word r12;
    t_word r20;
    t_word r21;
    t_word r22;
    logic  axis_was_zero;

    modport source (output valid, output r00, output r01, output r02, output r10,
                    output r11, output r12, output r20, output r21, output r22,
                    output axis_was_zero, input ready);
    modport sink   (input valid, input r00, input r01, input r02, input r10,
                    input r11, input r12, input r20, input r21, input r22,
                    input axis_was_zero, output ready);
endinterface

// File: rtl/axis_angle_rotation_matrix_top.sv
// throughput: one transaction per cycle while the output is ready; any stage holds only while the one after it is full
// depth is set by the 32-step square root and the 31-step divider, one step per stage
// reset: synchronous active low, clears the stage valid bits only
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_top_defines.svh"
module axis_angle_rotation_matrix_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aarm_in_if.sink    i_in,
    aarm_out_if.source o_out
);
    import aarm_pkg::*;

    localparam int NC = ST_SGN - ST_SUM;

    logic [NUM_ST-1:0] r_v;
    t_stage_vec        w_en;

    t_word [2:0]       w_axis;
    t_mag [2:0]        n_mag0, r_mag0, r_mag1, r_mag2;
    logic [2:0]        r_neg0, r_neg1, r_neg2;
    logic [SW-1:0]     r_sq [3];
    logic [SW-1:0]     r_sum;
    t_cw               n_a1, r_a1, n_a2;
    logic              n_aneg, r_aneg1;
    t_cw               r_z0;
    t_cw               r_cx [NC];
    t_cw               r_cy [NC];
    t_cw               r_cz [CORDIC_RUN-1];
    logic              r_caneg [NC];
    t_word [2:0]       w_n;
    logic              w_zero;
    t_cw               r_c, r_s, r_d, r_c1, r_c2;
    t_cw               r_p [6];
    t_cw               r_t [6];
    t_cw               r_ps [3];
    t_cw               r_ps2 [3];
    logic              r_zero1, r_zero2;
    t_word             n_m [9];
    t_word             r_m [9];
    logic              r_mzero;

    // ready ripples back from the output; empty stages always take data
    always_comb begin
        w_en[NUM_ST-1] = !r_v[NUM_ST-1] || o_out.ready;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (w_en & {r_v[NUM_ST-2:0], i_in.valid}) | (~w_en & r_v);
        end
    end

    assign w_axis = {i_in.axis_z, i_in.axis_y, i_in.axis_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag0[i] = w_axis[i][W-1] ? t_mag'(-w_axis[i]) : t_mag'(w_axis[i]);
        end
        n_a1 = t_cw'(i_in.angle);
        if (n_a1 >= PI_Q28) begin
            n_a1 = n_a1 - TWO_PI_Q28;
        end else if (n_a1 < -PI_Q28) begin
            n_a1 = n_a1 + TWO_PI_Q28;
        end
    end

    // fold into the right half plane, sign fixed up after the rotations
    always_comb begin
        n_a2   = r_a1;
        n_aneg = 1'b0;
        if (r_a1 > HALF_PI_Q28) begin
            n_a2   = r_a1 - PI_Q28;
            n_aneg = 1'b1;
        end else if (r_a1 < -HALF_PI_Q28) begin
            n_a2   = r_a1 + PI_Q28;
            n_aneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_IN]) begin
            r_mag0 <= n_mag0;
            r_neg0 <= {w_axis[2][W-1], w_axis[1][W-1], w_axis[0][W-1]};
            r_a1   <= n_a1;
        end
        if (w_en[ST_SQ]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SW'(r_mag0[i]) * SW'(r_mag0[i]);
            end
            r_mag1  <= r_mag0;
            r_neg1  <= r_neg0;
            r_z0    <= n_a2 <<< 2;
            r_aneg1 <= n_aneg;
        end
        if (w_en[ST_SUM]) begin
            r_sum  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
        end
    end

    aarm_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sum  (r_sum),
        .i_mag  (r_mag2),
        .i_neg  (r_neg2),
        .o_n    (w_n),
        .o_zero (w_zero)
    );

    // cordic rotations run alongside the sum, normalise and root stages, then idle stages carry
    genvar c;
    for (c = 0; c < NC; c++) begin : g_cordic
        if (c == 0) begin : g_flag0
            always_ff @(posedge i_clk) begin
                if (w_en[ST_SUM]) begin
                    r_caneg[c] <= r_aneg1;
                end
            end
        end else begin : g_flag
            always_ff @(posedge i_clk) begin
                if (w_en[ST_SUM+c]) begin
                    r_caneg[c] <= r_caneg[c-1];
                end
            end
        end

        if (c < CORDIC_RUN) begin : g_rot
            t_cw xin, yin, zin, xn, yn, zn;
            if (c == 0) begin : g_first
                assign xin = GAIN_Q30;
                assign yin = '0;
                assign zin = r_z0;
            end else begin : g_next
                assign xin = r_cx[c-1];
                assign yin = r_cy[c-1];
                assign zin = r_cz[c-1];
            end

            always_comb begin
                if (!zin[CW-1]) begin
                    xn = xin - (yin >>> c);
                    yn = yin + (xin >>> c);
                    zn = zin - t_cw'(ATAN_TAB[c]);
                end else begin
                    xn = xin + (yin >>> c);
                    yn = yin - (xin >>> c);
                    zn = zin + t_cw'(ATAN_TAB[c]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[ST_SUM+c]) begin
                    r_cx[c] <= xn;
                    r_cy[c] <= yn;
                end
            end

            if (c < CORDIC_RUN - 1) begin : g_angle
                always_ff @(posedge i_clk) begin
                    if (w_en[ST_SUM+c]) begin
                        r_cz[c] <= zn;
                    end
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (w_en[ST_SUM+c]) begin
                    r_cx[c] <= r_cx[c-1];
                    r_cy[c] <= r_cy[c-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SGN]) begin
            r_c <= r_caneg[NC-1] ? -r_cx[NC-1] : r_cx[NC-1];
            r_s <= r_caneg[NC-1] ? -r_cy[NC-1] : r_cy[NC-1];
        end
        if (w_en[ST_MUL1]) begin
            r_d     <= ONE_Q30 - r_c;
            r_p[0]  <= mul_q30(t_cw'($signed(w_n[0])), t_cw'($signed(w_n[0])));
            r_p[1]  <= mul_q30(t_cw'($signed(w_n[1])), t_cw'($signed(w_n[1])));
            r_p[2]  <= mul_q30(t_cw'($signed(w_n[2])), t_cw'($signed(w_n[2])));
            r_p[3]  <= mul_q30(t_cw'($signed(w_n[0])), t_cw'($signed(w_n[1])));
            r_p[4]  <= mul_q30(t_cw'($signed(w_n[0])), t_cw'($signed(w_n[2])));
            r_p[5]  <= mul_q30(t_cw'($signed(w_n[1])), t_cw'($signed(w_n[2])));
            for (int i = 0; i < 3; i++) begin
                r_ps[i] <= mul_q30(t_cw'($signed(w_n[i])), r_s);
            end
            r_c1    <= r_c;
            r_zero1 <= w_zero;
        end
        if (w_en[ST_MUL2]) begin
            for (int i = 0; i < 6; i++) begin
                r_t[i] <= mul_q30(r_p[i], r_d);
            end
            r_ps2   <= r_ps;
            r_c2    <= r_c1;
            r_zero2 <= r_zero1;
        end
    end

    // r_t order: xx yy zz xy xz yz; r_ps2 order: xs ys zs
    always_comb begin
        n_m[0] = sat_word((CW+1)'(r_t[0]) + (CW+1)'(r_c2));
        n_m[1] = sat_word((CW+1)'(r_t[3]) - (CW+1)'(r_ps2[2]));
        n_m[2] = sat_word((CW+1)'(r_t[4]) + (CW+1)'(r_ps2[1]));
        n_m[3] = sat_word((CW+1)'(r_t[3]) + (CW+1)'(r_ps2[2]));
        n_m[4] = sat_word((CW+1)'(r_t[1]) + (CW+1)'(r_c2));
        n_m[5] = sat_word((CW+1)'(r_t[5]) - (CW+1)'(r_ps2[0]));
        n_m[6] = sat_word((CW+1)'(r_t[4]) - (CW+1)'(r_ps2[1]));
        n_m[7] = sat_word((CW+1)'(r_t[5]) + (CW+1)'(r_ps2[0]));
        n_m[8] = sat_word((CW+1)'(r_t[2]) + (CW+1)'(r_c2));
        if (r_zero2) begin
            for (int i = 0; i < 9; i++) begin
                n_m[i] = (i % 4 == 0) ? ONE_WORD : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_m     <= n_m;
            r_mzero <= r_zero2;
        end
    end

    assign i_in.ready          = w_en[ST_IN];
    assign o_out.valid         = r_v[ST_OUT];
    assign o_out.r00           = r_m[0];
    assign o_out.r01           = r_m[1];
    assign o_out.r02           = r_m[2];
    assign o_out.r10           = r_m[3];
    assign o_out.r11           = r_m[4];
    assign o_out.r12           = r_m[5];
    assign o_out.r20           = r_m[6];
    assign o_out.r21           = r_m[7];
    assign o_out.r22           = r_m[8];
    assign o_out.axis_was_zero = r_mzero;

    `AARM_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in.valid && i_in.ready, r_v[ST_IN], "taken transaction lost at entry")
    `AARM_ASSERT_NOW(a_stall_when_full, i_clk, i_rst_n, !i_in.ready, (&r_v) && !o_out.ready, "input held back with room in pipe")
    `AARM_ASSERT_NOW(a_zero_identity, i_clk, i_rst_n, o_out.valid && r_mzero, r_m[0] == ONE_WORD && r_m[1] == '0 && r_m[8] == ONE_WORD, "zero axis without identity")

endmodule

// File: rtl/aarm_norm.sv
`timescale 1ns / 1ps
module aarm_norm (
    input  logic                         i_clk,
    input  aarm_pkg::t_stage_vec         i_en,
    input  logic [aarm_pkg::SW-1:0]      i_sum,
    input  aarm_pkg::t_mag [2:0]         i_mag,
    input  logic [2:0]                   i_neg,
    output aarm_pkg::t_word [2:0]        o_n,
    output logic                         o_zero
);
    import aarm_pkg::*;

    localparam int NH = ST_NUM - ST_NRM_A;
    localparam int NK = ST_SGN - ST_NRM_A;

    logic [SW-1:0]          n_s_a, n_s_b, r_s_a, r_s_b;
    t_shamt                 n_h_a, n_h_b;
    t_mag [2:0]             r_mag [NH];
    t_shamt                 r_h [NH];
    logic [2:0]             r_neg [NK];
    logic                   r_zero [NK];
    logic [SW-1:0]          r_sr_s [SQRT_STEPS-1];
    logic [SW-1:0]          r_sr_res [SQRT_STEPS];
    logic [W-1:0]           r_dv [DIV_STEPS];
    logic [2:0][W-1:0]      r_rem [DIV_STEPS];
    logic [2:0][DIV_STEPS-1:0] r_low [DIV_STEPS];
    logic [2:0][DIV_STEPS-1:0] r_q [DIV_STEPS];
    logic [W-1:0]           w_root;
    logic [2:0][NW-1:0]     n_num;
    t_word [2:0]            r_n;
    logic                   r_zero_o;

    // even left shift until one of the top two bits is set
    always_comb begin
        n_s_a = i_sum;
        n_h_a = '0;
        if (n_s_a[SW-1 -: 32] == '0) begin
            n_s_a = n_s_a << 32;
            n_h_a = n_h_a + t_shamt'(16);
        end
        if (n_s_a[SW-1 -: 16] == '0) begin
            n_s_a = n_s_a << 16;
            n_h_a = n_h_a + t_shamt'(8);
        end
    end

    always_comb begin
        n_s_b = r_s_a;
        n_h_b = r_h[0];
        if (n_s_b[SW-1 -: 8] == '0) begin
            n_s_b = n_s_b << 8;
            n_h_b = n_h_b + t_shamt'(4);
        end
        if (n_s_b[SW-1 -: 4] == '0) begin
            n_s_b = n_s_b << 4;
            n_h_b = n_h_b + t_shamt'(2);
        end
        if (n_s_b[SW-1 -: 2] == '0) begin
            n_s_b = n_s_b << 2;
            n_h_b = n_h_b + t_shamt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_NRM_A]) begin
            r_s_a  <= n_s_a;
        end
        if (i_en[ST_NRM_B]) begin
            r_s_b  <= n_s_b;
        end
    end

    genvar k, j;

    for (k = 0; k < NH; k++) begin : g_mag
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en[ST_NRM_A]) begin
                    r_mag[k] <= i_mag;
                    r_h[k]   <= n_h_a;
                end
            end
        end else if (k == 1) begin : g_second
            always_ff @(posedge i_clk) begin
                if (i_en[ST_NRM_B]) begin
                    r_mag[k] <= r_mag[k-1];
                    r_h[k]   <= n_h_b;
                end
            end
        end else begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[ST_NRM_A+k]) begin
                    r_mag[k] <= r_mag[k-1];
                    r_h[k]   <= r_h[k-1];
                end
            end
        end
    end

    for (k = 0; k < NK; k++) begin : g_flag
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en[ST_NRM_A]) begin
                    r_neg[k]  <= i_neg;
                    r_zero[k] <= (i_sum == '0);
                end
            end
        end else begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[ST_NRM_A+k]) begin
                    r_neg[k]  <= r_neg[k-1];
                    r_zero[k] <= r_zero[k-1];
                end
            end
        end
    end

    // integer square root, one result bit per stage
    for (j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * j);
        logic [SW-1:0] s_in, res_in, s_nx, res_nx;
        logic [SW:0]   trial;

        if (j == 0) begin : g_first
            assign s_in   = r_s_b;
            assign res_in = '0;
        end else begin : g_next
            assign s_in   = r_sr_s[j-1];
            assign res_in = r_sr_res[j-1];
        end

        always_comb begin
            trial = {1'b0, res_in} + {1'b0, BIT};
            if ({1'b0, s_in} >= trial) begin
                s_nx   = s_in - trial[SW-1:0];
                res_nx = (res_in >> 1) + BIT;
            end else begin
                s_nx   = s_in;
                res_nx = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[ST_SQRT0+j]) begin
                r_sr_res[j] <= res_nx;
            end
        end

        if (j < SQRT_STEPS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en[ST_SQRT0+j]) begin
                    r_sr_s[j] <= s_nx;
                end
            end
        end
    end

    // numerator: |a| * 2^h in q30 plus half the root for rounding
    assign w_root = r_sr_res[SQRT_STEPS-1][W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = NW'({r_mag[NH-1][i] << r_h[NH-1], {FRAC{1'b0}}})
                     + NW'(w_root[W-1:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_NUM]) begin
            r_dv[0] <= w_root;
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= n_num[i][NW-1:DIV_STEPS];
                r_low[0][i] <= n_num[i][DIV_STEPS-1:0];
            end
        end
    end

    // restoring divide, one quotient bit per stage for all three axes
    for (j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [2:0][DIV_STEPS-1:0] q_in, q_nx;
        logic [2:0][W-1:0]         rem_nx;
        logic [W:0]                trial;

        if (j == 0) begin : g_first
            assign q_in = '0;
        end else begin : g_next
            assign q_in = r_q[j-1];
        end

        always_comb begin
            trial = '0;
            for (int i = 0; i < 3; i++) begin
                trial = {r_rem[j][i], r_low[j][i][DIV_STEPS-1-j]};
                if (trial >= {1'b0, r_dv[j]}) begin
                    rem_nx[i] = W'(trial - {1'b0, r_dv[j]});
                    q_nx[i]   = {q_in[i][DIV_STEPS-2:0], 1'b1};
                end else begin
                    rem_nx[i] = trial[W-1:0];
                    q_nx[i]   = {q_in[i][DIV_STEPS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[ST_DIV0+j]) begin
                r_q[j] <= q_nx;
            end
        end

        if (j < DIV_STEPS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en[ST_DIV0+j]) begin
                    r_dv[j+1]  <= r_dv[j];
                    r_rem[j+1] <= rem_nx;
                    r_low[j+1] <= r_low[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_SGN]) begin
            for (int i = 0; i < 3; i++) begin
                if (r_neg[NK-1][i]) begin
                    r_n[i] <= -t_word'({1'b0, r_q[DIV_STEPS-1][i]});
                end else begin
                    r_n[i] <= t_word'({1'b0, r_q[DIV_STEPS-1][i]});
                end
            end
            r_zero_o <= r_zero[NK-1];
        end
    end

    assign o_n    = r_n;
    assign o_zero = r_zero_o;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import aarm_pkg::*;

    typedef struct packed {
        t_word r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic  axis_was_zero;
    } t_matrix;

    localparam int WATCHDOG_LIMIT = 20000;

    // rodrigues matrix predictor, 64-bit signed arithmetic
    function automatic longint q30_prod(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void cordic_sin_cos(longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        int atan_tab [30] = '{
            843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149,
            1048576, 524288, 262144, 131072, 65536,
            32768, 16384, 8192, 4096, 2048,
            1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        x = 652032874;
        y = 0;
        flip = 0;
        if (ang >= 843314857) ang -= 1686629713;
        else if (ang < -843314857) ang += 1686629713;
        if (ang > 421657428) begin
            ang -= 843314857;
            flip = 1;
        end else if (ang < -421657428) begin
            ang += 843314857;
            flip = 1;
        end
        z = ang * 4;
        for (int i = 0; i < CORDIC_RUN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_matrix rotation_matrix(t_word ax, t_word ay, t_word az, t_word ang);
        longint a [3];
        longint n [3];
        longint m [9];
        longint unsigned mag, sum, root, q;
        longint c, s, d, xy, xz, yz, xs, ys, zs;
        int k;
        t_matrix r;
        a[0] = ax; a[1] = ay; a[2] = az;
        sum = 0;
        k = 0;
        for (int i = 0; i < 3; i++) begin
            mag = a[i] < 0 ? -a[i] : a[i];
            sum += mag * mag;
        end
        if (sum == 0) begin
            r = '0;
            r.r00 = ONE_WORD; r.r11 = ONE_WORD; r.r22 = ONE_WORD;
            r.axis_was_zero = 1'b1;
            return r;
        end
        while ((sum >> 62) == 0) begin
            sum <<= 2;
            k += 2;
        end
        root = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            mag = a[i] < 0 ? -a[i] : a[i];
            q = ((mag << (k / 2 + 30)) + root / 2) / root;
            n[i] = a[i] < 0 ? -longint'(q) : longint'(q);
        end
        cordic_sin_cos(longint'(ang), c, s);
        d = 64'sd1073741824 - c;
        xy = q30_prod(q30_prod(n[0], n[1]), d);
        xz = q30_prod(q30_prod(n[0], n[2]), d);
        yz = q30_prod(q30_prod(n[1], n[2]), d);
        xs = q30_prod(n[0], s);
        ys = q30_prod(n[1], s);
        zs = q30_prod(n[2], s);
        m[0] = q30_prod(q30_prod(n[0], n[0]), d) + c;
        m[1] = xy - zs;
        m[2] = xz + ys;
        m[3] = xy + zs;
        m[4] = q30_prod(q30_prod(n[1], n[1]), d) + c;
        m[5] = yz - xs;
        m[6] = xz - ys;
        m[7] = yz + xs;
        m[8] = q30_prod(q30_prod(n[2], n[2]), d) + c;
        r.r00 = t_word'(clamp32(m[0])); r.r01 = t_word'(clamp32(m[1]));
        r.r02 = t_word'(clamp32(m[2])); r.r10 = t_word'(clamp32(m[3]));
        r.r11 = t_word'(clamp32(m[4])); r.r12 = t_word'(clamp32(m[5]));
        r.r20 = t_word'(clamp32(m[6])); r.r21 = t_word'(clamp32(m[7]));
        r.r22 = t_word'(clamp32(m[8]));
        r.axis_was_zero = 1'b0;
        return r;
    endfunction

    class matrix_scoreboard;
        t_matrix pending_matrices[$];
        int errors;
        int checked;
        int zero_axes;

        function void note_input(t_word ax, t_word ay, t_word az, t_word ang);
            t_matrix m;
            m = rotation_matrix(ax, ay, az, ang);
            if (m.axis_was_zero) zero_axes++;
            pending_matrices.push_back(m);
        endfunction

        function void check_result(t_matrix got);
            t_matrix want;
            if (pending_matrices.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending_matrices.pop_front();
            checked++;
            for (int i = 0; i < 9; i++) begin
                if (want[32*(8-i)+1 +: 32] !== got[32*(8-i)+1 +: 32]) begin
                    $display("%0t: entry %0d expected %0d actual %0d", $realtime, i,
                             $signed(want[32*(8-i)+1 +: 32]),
                             $signed(got[32*(8-i)+1 +: 32]));
                    errors++;
                end
            end
            if (want.axis_was_zero !== got.axis_was_zero) begin
                $display("%0t: axis_was_zero expected %0b actual %0b", $realtime,
                         want.axis_was_zero, got.axis_was_zero);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    aarm_in_if  in_ch ();
    aarm_out_if out_ch ();
    matrix_scoreboard board;
    int idle_cycles;
    bit stim_done;
    bit timed_out;
    int sent;

    axis_angle_rotation_matrix_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // receiver stall pattern: phases of full rate, phases of random stall, phases of a repeating stall pattern
    initial begin
        int mode;
        int phase;
        out_ch.ready = 1'b0;
        mode = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (phase == 0) begin
                mode = $urandom_range(0, 3);
                phase = $urandom_range(5, 80);
            end
            phase--;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= (phase % 7) < 3;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                board.note_input(in_ch.axis_x, in_ch.axis_y, in_ch.axis_z, in_ch.angle);
            end
            if (out_ch.valid && out_ch.ready) begin
                board.check_result({out_ch.r00, out_ch.r01, out_ch.r02, out_ch.r10,
                                    out_ch.r11, out_ch.r12, out_ch.r20, out_ch.r21,
                                    out_ch.r22, out_ch.axis_was_zero});
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (!in_ch.valid && board.pending_matrices.size() == 0)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // one transaction; the valid stays high into the next call when back to back
    task automatic send_axis_angle(t_word ax, t_word ay, t_word az, t_word ang);
        in_ch.valid  <= 1'b1;
        in_ch.axis_x <= ax;
        in_ch.axis_y <= ay;
        in_ch.axis_z <= az;
        in_ch.angle  <= ang;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic pause_sender(int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    function automatic t_word random_component();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom);
            1: return t_word'($signed($urandom_range(0, 131072)) - 65536);
            2: return t_word'(0);
            3: return $urandom_range(0, 1) ? t_word'(32'h8000_0000) : t_word'(32'h7fff_ffff);
            4: return t_word'($signed($urandom_range(0, 2)) - 1);
            default: return t_word'($urandom) >>> $urandom_range(0, 30);
        endcase
    endfunction

    function automatic t_word random_angle();
        case ($urandom_range(0, 4))
            0: return t_word'($urandom);
            1: return t_word'($signed($urandom_range(0, 1686629713)) - 843314857);
            2: return t_word'(421657428 + $signed($urandom_range(0, 4)) - 2);
            3: return t_word'(-843314857 + $signed($urandom_range(0, 4)) - 2);
            default: return t_word'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    task automatic run_directed();
        t_word angles [12] = '{32'sd0, 32'sd843314857, -32'sd843314857, 32'sd843314856,
                               32'sd421657428, 32'sd421657429, -32'sd421657428,
                               -32'sd421657429, 32'sh7fff_ffff, 32'sh8000_0000,
                               32'sd210828714, -32'sd1};
        foreach (angles[i]) send_axis_angle(32'sd65536, 32'sd0, 32'sd0, angles[i]);
        send_axis_angle(32'sd0, 32'sd0, 32'sd0, 32'sd421657428);
        send_axis_angle(32'sd0, 32'sd0, 32'sd0, 32'sh8000_0000);
        send_axis_angle(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sd123456789);
        send_axis_angle(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, -32'sd123456789);
        send_axis_angle(32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, 32'sd300000000);
        send_axis_angle(32'sd1, 32'sd0, 32'sd0, 32'sd100000000);
        send_axis_angle(32'sd0, -32'sd1, 32'sd0, 32'sd100000000);
        send_axis_angle(32'sd0, 32'sd0, 32'sd1, -32'sd100000000);
        send_axis_angle(32'sd65536, 32'sd65536, 32'sd65536, 32'sd562209905);
        send_axis_angle(-32'sd1, 32'sh7fff_ffff, 32'sd0, 32'sd843314857);
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.axis_x = '0;
        in_ch.axis_y = '0;
        in_ch.axis_z = '0;
        in_ch.angle = '0;
        idle_cycles = 0;
        stim_done = 0;
        timed_out = 0;
        sent = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        while (sent < 1620) begin
            repeat ($urandom_range(1, 60)) begin
                send_axis_angle(random_component(), random_component(), random_component(),
                                random_angle());
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (board.pending_matrices.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (timed_out) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        $display("%0d matrices checked, %0d with a zero axis", board.checked,
                 board.zero_axes);
        $display("axes and angles spanned full range, wrap and quadrant edges, stalls");
        if (board.errors == 0 && board.pending_matrices.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1;
        $display("%0t: watchdog expired", $realtime);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/aarm_pkg.sv
rtl/aarm_in_if.sv
rtl/aarm_out_if.sv
rtl/aarm_norm.sv
rtl/axis_angle_rotation_matrix_top.sv
tb/testbench.sv
